FILE: rtl/core/assert_macros.svh
// assertion macros shared by the rtl core
// both sample on the rising edge of clk and are off while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property that must hold at every edge
`define UPDS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication checked in the same cycle
`define UPDS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/upds_pkg.sv
// ----------------------------------------------------------------------------
// upds_pkg
// Widths, reset values and register indexes of the up/down pot stepper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package upds_pkg;

	localparam int unsigned POS_W    = 7;
	localparam int unsigned TARGET_W = 8;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 7;
	localparam int unsigned POT_COUNT = 2;

	localparam logic [POS_W-1:0] POSITION_MAX_RESET = 7'd100;
	localparam logic [POS_W-1:0] INIT_PULSES_RESET  = 7'd100;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_POSITION_MAX = 1'b0,
		CFG_INIT_PULSES  = 1'b1
	} cfg_idx_t;

	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_MOVE = 1'b1;

endpackage

`default_nettype wire

FILE: rtl/core/updown_digital_pot_stepper.sv
// ----------------------------------------------------------------------------
// updown_digital_pot_stepper
// Drives two increment/up-down digital pots and tracks each wiper position.
// ----------------------------------------------------------------------------
// One input item is taken every cycle while the output register is free or
// being emptied; its result (pin levels, busy and drop flags) sits in the
// output register the next cycle. Each item needs a single pass through the
// phase decode between the state registers and the result register, so the
// sustained rate is one item per clock. After reset the block homes pot 0
// and then pot 1, each with init_pulses pulses (two ticks per pulse plus a
// start and an end tick), and reports busy until both positions read zero.
// Move requests that arrive while busy are dropped and flagged.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module updown_digital_pot_stepper (
	input  wire logic clk,
	input  wire logic arst_n,

	// configuration write channel
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [upds_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [upds_pkg::CFG_DATA_W-1:0]    cfg_data,

	// input items
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic                               kind,
	input  wire logic                               pot_id,
	input  wire logic [upds_pkg::TARGET_W-1:0]      target_position,

	// result items
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic                                    select0_n,
	output logic                                    select1_n,
	output logic                                    inc_level,
	output logic                                    updown_level,
	output logic                                    busy_res,
	output logic                                    request_dropped
);

	typedef enum logic [2:0] {
		PH_IDLE       = 3'd0,
		PH_HOME_START = 3'd1,
		PH_HOME_LOW   = 3'd2,
		PH_HOME_HIGH  = 3'd3,
		PH_MOVE_LOW   = 3'd4,
		PH_MOVE_HIGH  = 3'd5
	} phase_t;

	localparam int unsigned PW = upds_pkg::POS_W;

	// configuration
	logic [PW-1:0] position_max_q;
	logic [PW-1:0] init_pulses_q;

	// stepper state
	phase_t        phase_q, phase_d;
	logic [PW-1:0] steps_q, steps_d;
	logic          act_q, act_d;
	logic [PW-1:0] tgt_q, tgt_d;
	logic [PW-1:0] wiper_q [upds_pkg::POT_COUNT];
	logic [PW-1:0] wiper_d [upds_pkg::POT_COUNT];
	logic          sel0_q, sel0_d;
	logic          sel1_q, sel1_d;
	logic          inc_q, inc_d;
	logic          ud_q, ud_d;
	logic          dropped;

	// output register
	logic out_valid_q;
	logic sel0_out_q, sel1_out_q, inc_out_q, ud_out_q, busy_out_q, drop_out_q;

	logic          in_acc;
	logic [PW-1:0] clamped;
	logic [PW-1:0] cur_pos;
	logic          going_down;

	assign cfg_ready = 1'b1;
	assign in_stall  = out_valid_q & out_stall;
	assign in_acc    = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_max_q <= upds_pkg::POSITION_MAX_RESET;
			init_pulses_q  <= upds_pkg::INIT_PULSES_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (upds_pkg::cfg_idx_t'(cfg_index))
				upds_pkg::CFG_POSITION_MAX: position_max_q <= cfg_data;
				upds_pkg::CFG_INIT_PULSES:  init_pulses_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp and direction for a move request
	assign clamped    = (target_position > {1'b0, position_max_q}) ?
		position_max_q : target_position[PW-1:0];
	assign cur_pos    = wiper_q[pot_id];
	assign going_down = cur_pos > clamped;

	always_comb begin
		phase_d    = phase_q;
		steps_d    = steps_q;
		act_d      = act_q;
		tgt_d      = tgt_q;
		wiper_d[0] = wiper_q[0];
		wiper_d[1] = wiper_q[1];
		sel0_d     = sel0_q;
		sel1_d     = sel1_q;
		inc_d      = inc_q;
		ud_d       = ud_q;
		dropped    = 1'b0;

		if (kind == upds_pkg::KIND_TICK) begin
			unique case (phase_q)
				PH_IDLE: ;
				PH_HOME_START: begin
					sel0_d  = act_q;
					sel1_d  = ~act_q;
					inc_d   = 1'b0;
					ud_d    = 1'b0;
					steps_d = init_pulses_q;
					phase_d = PH_HOME_LOW;
				end
				PH_HOME_LOW, PH_MOVE_LOW: begin
					if (steps_q != '0) begin
						inc_d   = 1'b1;
						phase_d = (phase_q == PH_HOME_LOW) ? PH_HOME_HIGH : PH_MOVE_HIGH;
					end else begin
						// release the select of the pot just stepped
						if (act_q) begin
							sel1_d = 1'b1;
						end else begin
							sel0_d = 1'b1;
						end
						if (phase_q == PH_HOME_LOW) begin
							if (!act_q) begin
								act_d   = 1'b1;
								phase_d = PH_HOME_START;
							end else begin
								wiper_d[0] = '0;
								wiper_d[1] = '0;
								act_d      = 1'b0;
								phase_d    = PH_IDLE;
							end
						end else begin
							wiper_d[act_q] = tgt_q;
							phase_d        = PH_IDLE;
						end
					end
				end
				PH_HOME_HIGH, PH_MOVE_HIGH: begin
					inc_d   = 1'b0;
					steps_d = steps_q - PW'(1);
					phase_d = (phase_q == PH_HOME_HIGH) ? PH_HOME_LOW : PH_MOVE_LOW;
				end
				default: begin
					sel0_d  = 1'b1;
					sel1_d  = 1'b1;
					inc_d   = 1'b0;
					ud_d    = 1'b0;
					phase_d = PH_IDLE;
				end
			endcase
		end else if (phase_q != PH_IDLE) begin
			dropped = 1'b1;
		end else if (cur_pos != clamped) begin
			act_d   = pot_id;
			tgt_d   = clamped;
			sel0_d  = pot_id;
			sel1_d  = ~pot_id;
			inc_d   = 1'b0;
			ud_d    = going_down;
			steps_d = going_down ? (cur_pos - clamped) : (clamped - cur_pos);
			phase_d = PH_MOVE_LOW;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HOME_START;
			steps_q    <= upds_pkg::INIT_PULSES_RESET;
			act_q      <= 1'b0;
			tgt_q      <= '0;
			wiper_q[0] <= '0;
			wiper_q[1] <= '0;
			sel0_q     <= 1'b1;
			sel1_q     <= 1'b1;
			inc_q      <= 1'b0;
			ud_q       <= 1'b0;
		end else if (in_acc) begin
			phase_q    <= phase_d;
			steps_q    <= steps_d;
			act_q      <= act_d;
			tgt_q      <= tgt_d;
			wiper_q[0] <= wiper_d[0];
			wiper_q[1] <= wiper_d[1];
			sel0_q     <= sel0_d;
			sel1_q     <= sel1_d;
			inc_q      <= inc_d;
			ud_q       <= ud_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, loaded with every accepted transaction
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sel0_out_q <= sel0_d;
			sel1_out_q <= sel1_d;
			inc_out_q  <= inc_d;
			ud_out_q   <= ud_d;
			busy_out_q <= (phase_d != PH_IDLE);
			drop_out_q <= dropped;
		end
	end

	assign out_valid       = out_valid_q;
	assign select0_n       = sel0_out_q;
	assign select1_n       = sel1_out_q;
	assign inc_level       = inc_out_q;
	assign updown_level    = ud_out_q;
	assign busy_res        = busy_out_q;
	assign request_dropped = drop_out_q;

	`UPDS_ASSERT(a_one_select, !(!sel0_q && !sel1_q), "both pot selects active")
	`UPDS_ASSERT_IMPL(a_inc_needs_select, inc_q, (!sel0_q || !sel1_q),
		"inc high with no pot selected")
	`UPDS_ASSERT_IMPL(a_idle_pins, phase_q == PH_IDLE, (sel0_q && sel1_q && !inc_q),
		"pins not released while idle")
	`UPDS_ASSERT_IMPL(a_drop_while_busy, out_valid && request_dropped, busy_res,
		"request dropped while not busy")

endmodule

`default_nettype wire

FILE: sim/updown_digital_pot_stepper_tb.sv
// ----------------------------------------------------------------------------
// updown_digital_pot_stepper_tb
// Self-checking bench for the up/down pot stepper. Ticks and move requests go
// in through a queue-fed driver; every result is checked against an in-bench
// model of the pin sequencer. Sender idling, receiver stalls and the clamp and
// homing registers change from phase to phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module updown_digital_pot_stepper_tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 200;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HOME_START,
		ST_HOME_LOW,
		ST_HOME_HIGH,
		ST_MOVE_LOW,
		ST_MOVE_HIGH
	} seq_phase_t;

	typedef struct packed {
		logic                          kind;
		logic                          pot;
		logic [upds_pkg::TARGET_W-1:0] target;
	} pot_cmd_t;

	typedef struct packed {
		logic sel0_n;
		logic sel1_n;
		logic inc;
		logic ud;
		logic busy;
		logic dropped;
	} pin_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [upds_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [upds_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic                          kind = 1'b0;
	logic                          pot_id = 1'b0;
	logic [upds_pkg::TARGET_W-1:0] target_position = '0;

	logic out_valid;
	logic out_stall = 1'b0;
	logic select0_n;
	logic select1_n;
	logic inc_level;
	logic updown_level;
	logic busy_res;
	logic request_dropped;

	// model of the pin sequencer
	logic [upds_pkg::POS_W-1:0] m_pos_max;
	logic [upds_pkg::POS_W-1:0] m_init_pulses;
	logic [upds_pkg::POS_W-1:0] m_wiper [upds_pkg::POT_COUNT];
	seq_phase_t                 m_phase;
	logic [upds_pkg::POS_W-1:0] m_steps;
	logic                       m_active;
	logic [upds_pkg::POS_W-1:0] m_pending;
	logic                       m_sel0_n;
	logic                       m_sel1_n;
	logic                       m_inc;
	logic                       m_ud;

	pot_cmd_t    pending_cmds [$];
	pin_result_t pin_expect_q [$];
	pot_cmd_t    drv_cmd;

	int cmds_queued = 0;
	int cmds_accepted = 0;
	int mismatches = 0;
	int cycle_count = 0;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int phase_items = 0;
	int est_pos [upds_pkg::POT_COUNT];
	int est_max;

	logic in_fire = 1'b0;
	int   hold_len = 0;
	logic hold_go = 1'b0;
	logic hold_seen = 1'b0;
	int   hold_left = 0;

	updown_digital_pot_stepper u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.kind            (kind),
		.pot_id          (pot_id),
		.target_position (target_position),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.select0_n       (select0_n),
		.select1_n       (select1_n),
		.inc_level       (inc_level),
		.updown_level    (updown_level),
		.busy_res        (busy_res),
		.request_dropped (request_dropped)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
	endtask

	function automatic pin_result_t apply_pot_cmd(input pot_cmd_t c);
		pin_result_t                r;
		logic                       dropped;
		logic [upds_pkg::POS_W-1:0] cur;
		logic [upds_pkg::POS_W-1:0] tgt;
		dropped = 1'b0;
		if (c.kind == upds_pkg::KIND_TICK) begin
			case (m_phase)
				ST_IDLE: begin
				end
				ST_HOME_START: begin
					m_sel0_n = m_active;
					m_sel1_n = !m_active;
					m_inc = 1'b0;
					m_ud = 1'b0;
					m_steps = m_init_pulses;
					m_phase = ST_HOME_LOW;
				end
				ST_HOME_LOW, ST_MOVE_LOW: begin
					if (m_steps != 0) begin
						m_inc = 1'b1;
						m_phase = (m_phase == ST_HOME_LOW) ? ST_HOME_HIGH : ST_MOVE_HIGH;
					end else begin
						if (m_active)
							m_sel1_n = 1'b1;
						else
							m_sel0_n = 1'b1;
						if (m_phase == ST_MOVE_LOW) begin
							m_wiper[m_active] = m_pending;
							m_phase = ST_IDLE;
						end else if (!m_active) begin
							m_active = 1'b1;
							m_phase = ST_HOME_START;
						end else begin
							m_wiper[0] = '0;
							m_wiper[1] = '0;
							m_active = 1'b0;
							m_phase = ST_IDLE;
						end
					end
				end
				ST_HOME_HIGH, ST_MOVE_HIGH: begin
					m_inc = 1'b0;
					m_steps = m_steps - 1'b1;
					m_phase = (m_phase == ST_HOME_HIGH) ? ST_HOME_LOW : ST_MOVE_LOW;
				end
				default: begin
					m_sel0_n = 1'b1;
					m_sel1_n = 1'b1;
					m_inc = 1'b0;
					m_ud = 1'b0;
					m_phase = ST_IDLE;
				end
			endcase
		end else if (m_phase != ST_IDLE) begin
			dropped = 1'b1;
		end else begin
			tgt = (c.target > m_pos_max) ? m_pos_max : c.target[upds_pkg::POS_W-1:0];
			cur = m_wiper[c.pot];
			if (cur != tgt) begin
				m_active = c.pot;
				m_pending = tgt;
				m_sel0_n = c.pot;
				m_sel1_n = !c.pot;
				m_inc = 1'b0;
				m_ud = (cur > tgt);
				m_steps = (cur > tgt) ? cur - tgt : tgt - cur;
				m_phase = ST_MOVE_LOW;
			end
		end
		r.sel0_n = m_sel0_n;
		r.sel1_n = m_sel1_n;
		r.inc = m_inc;
		r.ud = m_ud;
		r.busy = (m_phase != ST_IDLE);
		r.dropped = dropped;
		return r;
	endfunction

	// driver: a stalled transaction holds its payload
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_fire) begin
			if (pending_cmds.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				drv_cmd = pending_cmds.pop_front();
				in_valid <= 1'b1;
				kind <= drv_cmd.kind;
				pot_id <= drv_cmd.pot;
				target_position <= drv_cmd.target;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			pin_expect_q.push_back(apply_pot_cmd('{kind, pot_id, target_position}));
			cmds_accepted++;
			in_fire <= 1'b1;
		end else begin
			in_fire <= 1'b0;
		end
	end

	// receiver stalls, with an occasional long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_go != hold_seen) begin
			hold_seen <= hold_go;
			hold_left <= hold_len;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		pin_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pin_expect_q.size() == 0) begin
				report_mismatch("result transaction with nothing expected", 1, 0);
			end else begin
				want = pin_expect_q.pop_front();
				if (select0_n !== want.sel0_n)
					report_mismatch("select0_n", select0_n, want.sel0_n);
				if (select1_n !== want.sel1_n)
					report_mismatch("select1_n", select1_n, want.sel1_n);
				if (inc_level !== want.inc)
					report_mismatch("inc_level", inc_level, want.inc);
				if (updown_level !== want.ud)
					report_mismatch("updown_level", updown_level, want.ud);
				if (busy_res !== want.busy)
					report_mismatch("busy_res", busy_res, want.busy);
				if (request_dropped !== want.dropped)
					report_mismatch("request_dropped", request_dropped, want.dropped);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic push_cmd(input logic k, input logic p,
		input logic [upds_pkg::TARGET_W-1:0] t);
		pending_cmds.push_back('{k, p, t});
		cmds_queued++;
		phase_items++;
	endtask

	// tick fields carry random content, the block must ignore it
	task automatic push_ticks(input int n);
		int rp;
		int rt;
		for (int i = 0; i < n; i++) begin
			rp = $urandom_range(1);
			rt = $urandom_range(255);
			push_cmd(upds_pkg::KIND_TICK, rp[0], rt[upds_pkg::TARGET_W-1:0]);
		end
	endtask

	task automatic write_cfg(input upds_pkg::cfg_idx_t idx,
		input logic [upds_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == upds_pkg::CFG_POSITION_MAX)
			m_pos_max = val;
		else
			m_init_pulses = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait for every queued transaction and its result, then resync the
	// generator's view of the wiper positions
	task automatic wait_drained();
		do
			@(negedge clk);
		while (cmds_accepted != cmds_queued || pin_expect_q.size() != 0);
		est_pos[0] = int'(m_wiper[0]);
		est_pos[1] = int'(m_wiper[1]);
		est_max = int'(m_pos_max);
	endtask

	// one move request followed by exactly the ticks that finish it; a
	// request may be slipped in while the move runs, it must be dropped
	task automatic queue_move_sequence();
		logic p;
		int   rp;
		int   rt;
		int   sel;
		int   off;
		int   t;
		int   clamped;
		int   d;
		int   n;
		int   noise_at;
		rp = $urandom_range(1);
		p = rp[0];
		sel = $urandom_range(9);
		if (sel == 0) begin
			t = $urandom_range(255);
		end else if (sel == 1) begin
			t = est_pos[p];
		end else begin
			off = $urandom_range(1, 6);
			if ($urandom_range(1))
				t = est_pos[p] + off;
			else
				t = (est_pos[p] >= off) ? est_pos[p] - off : 0;
		end
		clamped = (t > est_max) ? est_max : t;
		d = (clamped > est_pos[p]) ? clamped - est_pos[p] : est_pos[p] - clamped;
		n = (d != 0) ? 2 * d + 1 : 0;
		noise_at = (n != 0 && $urandom_range(99) < 30) ? $urandom_range(n - 1) : -1;
		push_cmd(upds_pkg::KIND_MOVE, p, t[upds_pkg::TARGET_W-1:0]);
		for (int i = 0; i < n; i++) begin
			if (i == noise_at) begin
				rp = $urandom_range(1);
				rt = $urandom_range(255);
				push_cmd(upds_pkg::KIND_MOVE, rp[0], rt[upds_pkg::TARGET_W-1:0]);
			end
			push_ticks(1);
		end
		est_pos[p] = clamped;
		push_ticks($urandom_range(2));
	endtask

	initial begin
		int pmax;
		int ipulses;
		m_pos_max = upds_pkg::POSITION_MAX_RESET;
		m_init_pulses = upds_pkg::INIT_PULSES_RESET;
		m_wiper[0] = '0;
		m_wiper[1] = '0;
		m_phase = ST_HOME_START;
		m_steps = upds_pkg::INIT_PULSES_RESET;
		m_active = 1'b0;
		m_pending = '0;
		m_sel0_n = 1'b1;
		m_sel1_n = 1'b1;
		m_inc = 1'b0;
		m_ud = 1'b0;

		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// homing with no pulses, tight clamp so full-range targets stay short
		write_cfg(upds_pkg::CFG_INIT_PULSES, 7'd0);
		write_cfg(upds_pkg::CFG_POSITION_MAX, 7'd3);

		push_cmd(upds_pkg::KIND_MOVE, 1'b0, 8'd5);
		push_ticks(2);
		push_cmd(upds_pkg::KIND_MOVE, 1'b1, 8'd9);
		push_ticks(2);
		push_ticks(1);
		push_cmd(upds_pkg::KIND_MOVE, 1'b0, 8'd0);
		push_cmd(upds_pkg::KIND_MOVE, 1'b1, 8'd255);
		push_ticks(7);
		push_cmd(upds_pkg::KIND_MOVE, 1'b1, 8'd0);
		push_ticks(7);
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					tx_idle_pct = 0;
					rx_stall_pct = 0;
					pmax = 127;
					ipulses = 127;
				end
				1: begin
					tx_idle_pct = 55;
					rx_stall_pct = 0;
					pmax = 0;
					ipulses = $urandom_range(127);
				end
				2: begin
					tx_idle_pct = 0;
					rx_stall_pct = 55;
					pmax = 100;
					ipulses = $urandom_range(127);
				end
				default: begin
					tx_idle_pct = 21;
					rx_stall_pct = 21;
					pmax = $urandom_range(1, 127);
					ipulses = 0;
				end
			endcase
			write_cfg(upds_pkg::CFG_POSITION_MAX, pmax[upds_pkg::CFG_DATA_W-1:0]);
			write_cfg(upds_pkg::CFG_INIT_PULSES, ipulses[upds_pkg::CFG_DATA_W-1:0]);
			est_max = int'(m_pos_max);
			if (ph == 0) begin
				// long receiver hold-off while the sender keeps offering
				hold_len = 400;
				hold_go = !hold_go;
			end
			phase_items = 0;
			while (phase_items < PHASE_ITEMS)
				queue_move_sequence();
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (pin_expect_q.size() != 0)
			report_mismatch("results still expected at end", 0, pin_expect_q.size());
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
